>>> sv/assert_macros.svh
// Assertion macros for the checker file of the allocator.
// No dependencies; guarded against double inclusion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define ASSERT_CLK(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Condition that must never be seen outside of reset.
`define ASSERT_NEVER(name, clk, rstn, cond) \
  `ASSERT_CLK(name, clk, rstn, !(cond))

`endif

>>> sv/ffba_pkg.sv
// Shared types and codes of the first-fit block allocator.
// No dependencies; used by the memory, the top level and the checker.
`default_nettype none

package ffba_pkg;

  // Transaction kinds
  typedef enum logic [1:0] {
    KIND_INIT  = 2'd0,
    KIND_ALLOC = 2'd1,
    KIND_FREE  = 2'd2
  } kind_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NULL      = 3'd1,
    ST_FULL      = 3'd2,
    ST_UNKNOWN   = 3'd3,
    ST_NOT_OCC   = 3'd4,
    ST_TOO_SMALL = 3'd5
  } status_e;

  // Configuration register indexes
  typedef enum logic {
    CFG_REGION_BASE = 1'b0,
    CFG_REGION_SIZE = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] request_size;
    logic [12:0] alignment;
    logic [31:0] free_address;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] payload_address;
    logic [31:0] free_bytes;
  } out_item_t;

  // One block table entry
  typedef struct packed {
    logic [31:0] hdr;
    logic [31:0] size;
    logic        occ;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INIT,
    S_SCAN_RD,
    S_SCAN_EV,
    S_AL_RS,
    S_AL_RQ,
    S_AL_CMP,
    S_FR_CMP,
    S_INS_RD,
    S_INS_WR,
    S_AL_W1,
    S_AL_W2,
    S_FR_PRD,
    S_FR_PEV,
    S_FR_NRD,
    S_FR_NEV,
    S_FR_WM,
    S_RM_RD,
    S_RM_WR,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

>>> sv/ffba_mem.sv
// Block table memory: one write port, one registered read port.
// Depends on ffba_pkg for the entry type.
`default_nettype none

module ffba_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [AW-1:0]   waddr_i,
  input  wire ffba_pkg::entry_t wdata_i,
  input  wire logic [AW-1:0]   raddr_i,
  output ffba_pkg::entry_t     rdata_o
);

  ffba_pkg::entry_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

>>> sv/first_fit_block_allocator.sv
// Allocate scans for the first free block that fits, then shifts later entries up on a split;
// it ends early when the table is full or nothing fits. Deallocate scans for the block that
// holds the address, then merges free neighbors and shifts later entries down.
// One transaction at a time; next accept in the cycle after the result; results never stall.
// Async active-low reset clears control, count, free total and config; table is not cleared.
`default_nettype none

module first_fit_block_allocator #(
  parameter int HEADER_BYTES = 16,
  parameter int MAX_BLOCKS   = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire ffba_pkg::in_item_t req_i,
  output logic               done_o,
  output ffba_pkg::out_item_t res_o,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_idx_i,
  input  wire logic [31:0]   cfg_wdata_i
);

  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [35:0] H36 = 36'(HEADER_BYTES);
  localparam logic [31:0] H32 = 32'(HEADER_BYTES);
  localparam logic [32:0] TOP = 33'h1_0000_0000;

  ffba_pkg::state_e st_q, st_d;

  logic [31:0] base_q, rsize_q;
  logic [CW-1:0] cnt_q, scn_q, ptr_q;
  logic [31:0] ft_q;
  logic [1:0]  kind_q;
  logic [31:0] reqsz_q, faddr_q;
  logic [12:0] amask_q;
  logic [31:0] hdr_q, size_q;
  logic        occ_q;
  logic [32:0] avs_q;
  logic [33:0] ave_q, rs_q;
  logic [34:0] rsq_q;
  logic [31:0] acc_q, mhdr_q;
  logic        pfree_q, nfree_q;
  logic [2:0]  status_q;
  logic [31:0] addr_q;

  logic              mem_we;
  logic [IW-1:0]     mem_waddr, mem_raddr;
  ffba_pkg::entry_t  mem_wdata, mem_rdata;

  ffba_mem #(.DEPTH(MAX_BLOCKS), .AW(IW)) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Effective alignment mask: highest set bit, zero acts as one
  logic [12:0] apow;
  always_comb begin
    apow = 13'd1;
    for (int b = 0; b < 13; b++) begin
      if (req_i.alignment[b]) apow = 13'(13'd1 << b);
    end
  end

  // Index arithmetic
  logic [CW-1:0] scn_p1, scn_m1, ptr_p1, ptr_mk, kmrg;
  assign scn_p1 = CW'(scn_q + 1'b1);
  assign scn_m1 = CW'(scn_q - 1'b1);
  assign ptr_p1 = CW'(ptr_q + 1'b1);
  assign kmrg   = CW'({1'b0, pfree_q} + {1'b0, nfree_q});
  assign ptr_mk = CW'(ptr_q - kmrg);

  // Initialize: clip region at top of memory
  logic [32:0] init_end, init_eff;
  logic        init_small;
  assign init_end   = {1'b0, base_q} + {1'b0, rsize_q};
  assign init_eff   = (init_end > TOP) ? (TOP - {1'b0, base_q}) : {1'b0, rsize_q};
  assign init_small = init_eff < 33'(HEADER_BYTES);

  // Fit and lookup tests
  logic alloc_fit, free_hit, accept;
  assign alloc_fit = ({1'b0, rsq_q} + H36) <= {2'b0, ave_q};
  assign free_hit  = (faddr_q >= hdr_q) && ({2'b0, faddr_q} <= ave_q);
  assign accept    = start && !busy;

  // Next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ffba_pkg::S_IDLE: begin
        if (accept) begin
          case (req_i.kind)
            ffba_pkg::KIND_INIT:  st_d = ffba_pkg::S_INIT;
            ffba_pkg::KIND_ALLOC: st_d = (req_i.request_size == '0) ? ffba_pkg::S_DONE
                                                                     : ffba_pkg::S_SCAN_RD;
            ffba_pkg::KIND_FREE:  st_d = ffba_pkg::S_SCAN_RD;
            default:              st_d = ffba_pkg::S_DONE;
          endcase
        end
      end
      ffba_pkg::S_INIT:    st_d = ffba_pkg::S_DONE;
      ffba_pkg::S_SCAN_RD: st_d = (scn_q == cnt_q) ? ffba_pkg::S_DONE : ffba_pkg::S_SCAN_EV;
      ffba_pkg::S_SCAN_EV: begin
        if (kind_q == ffba_pkg::KIND_FREE) st_d = ffba_pkg::S_FR_CMP;
        else if (mem_rdata.occ)            st_d = ffba_pkg::S_SCAN_RD;
        else                               st_d = ffba_pkg::S_AL_RS;
      end
      ffba_pkg::S_AL_RS: st_d = ffba_pkg::S_AL_RQ;
      ffba_pkg::S_AL_RQ: st_d = ffba_pkg::S_AL_CMP;
      ffba_pkg::S_AL_CMP: begin
        if (!alloc_fit)                      st_d = ffba_pkg::S_SCAN_RD;
        else if (cnt_q >= CW'(MAX_BLOCKS))   st_d = ffba_pkg::S_DONE;
        else if (cnt_q > scn_p1)             st_d = ffba_pkg::S_INS_RD;
        else                                 st_d = ffba_pkg::S_AL_W1;
      end
      ffba_pkg::S_INS_RD: st_d = ffba_pkg::S_INS_WR;
      ffba_pkg::S_INS_WR: st_d = (ptr_q == scn_p1) ? ffba_pkg::S_AL_W1 : ffba_pkg::S_INS_RD;
      ffba_pkg::S_AL_W1:  st_d = ffba_pkg::S_AL_W2;
      ffba_pkg::S_AL_W2:  st_d = ffba_pkg::S_DONE;
      ffba_pkg::S_FR_CMP: begin
        if (!free_hit)               st_d = ffba_pkg::S_SCAN_RD;
        else if (!occ_q)             st_d = ffba_pkg::S_DONE;
        else if (scn_q != '0)        st_d = ffba_pkg::S_FR_PRD;
        else if (scn_p1 < cnt_q)     st_d = ffba_pkg::S_FR_NRD;
        else                         st_d = ffba_pkg::S_FR_WM;
      end
      ffba_pkg::S_FR_PRD: st_d = ffba_pkg::S_FR_PEV;
      ffba_pkg::S_FR_PEV: st_d = (scn_p1 < cnt_q) ? ffba_pkg::S_FR_NRD : ffba_pkg::S_FR_WM;
      ffba_pkg::S_FR_NRD: st_d = ffba_pkg::S_FR_NEV;
      ffba_pkg::S_FR_NEV: st_d = ffba_pkg::S_FR_WM;
      ffba_pkg::S_FR_WM:  st_d = ffba_pkg::S_RM_RD;
      ffba_pkg::S_RM_RD:  st_d = (ptr_q == cnt_q) ? ffba_pkg::S_DONE : ffba_pkg::S_RM_WR;
      ffba_pkg::S_RM_WR:  st_d = ffba_pkg::S_RM_RD;
      ffba_pkg::S_DONE:   st_d = ffba_pkg::S_IDLE;
      default:            st_d = ffba_pkg::S_IDLE;
    endcase
  end

  // Memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = mem_rdata;
    mem_raddr = scn_q[IW-1:0];
    case (st_q)
      ffba_pkg::S_INS_RD, ffba_pkg::S_RM_RD: mem_raddr = ptr_q[IW-1:0];
      ffba_pkg::S_FR_PRD: mem_raddr = scn_m1[IW-1:0];
      ffba_pkg::S_FR_NRD: mem_raddr = scn_p1[IW-1:0];
      ffba_pkg::S_INIT: begin
        mem_we    = !init_small;
        mem_wdata = '{hdr: base_q, size: init_eff[31:0] - H32, occ: 1'b0};
      end
      ffba_pkg::S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_p1[IW-1:0];
      end
      ffba_pkg::S_AL_W1: begin
        mem_we    = 1'b1;
        mem_waddr = scn_p1[IW-1:0];
        mem_wdata = '{hdr: rsq_q[31:0], size: ave_q[31:0] - rsq_q[31:0] - H32, occ: 1'b0};
      end
      ffba_pkg::S_AL_W2: begin
        mem_we    = 1'b1;
        mem_waddr = scn_q[IW-1:0];
        mem_wdata = '{hdr: hdr_q, size: rsq_q[31:0] - avs_q[31:0], occ: 1'b1};
      end
      ffba_pkg::S_FR_WM: begin
        mem_we    = 1'b1;
        mem_waddr = pfree_q ? scn_m1[IW-1:0] : scn_q[IW-1:0];
        mem_wdata = '{hdr: mhdr_q, size: acc_q, occ: 1'b0};
      end
      ffba_pkg::S_RM_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_mk[IW-1:0];
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ffba_pkg::S_IDLE;
      cnt_q    <= '0;
      ft_q     <= '0;
      base_q   <= '0;
      rsize_q  <= '0;
      status_q <= ffba_pkg::ST_OK;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == ffba_pkg::CFG_REGION_BASE) base_q  <= cfg_wdata_i;
        else                                        rsize_q <= cfg_wdata_i;
      end
      case (st_q)
        ffba_pkg::S_IDLE: status_q <= ffba_pkg::ST_NULL;
        ffba_pkg::S_INIT: begin
          if (init_small) begin
            status_q <= ffba_pkg::ST_TOO_SMALL;
          end else begin
            status_q <= ffba_pkg::ST_OK;
            cnt_q    <= CW'(1);
            ft_q     <= init_eff[31:0] - H32;
          end
        end
        ffba_pkg::S_SCAN_RD: begin
          if (scn_q == cnt_q && kind_q == ffba_pkg::KIND_FREE) status_q <= ffba_pkg::ST_UNKNOWN;
        end
        ffba_pkg::S_AL_CMP: begin
          if (alloc_fit && cnt_q >= CW'(MAX_BLOCKS)) status_q <= ffba_pkg::ST_FULL;
        end
        ffba_pkg::S_AL_W1: begin
          ft_q <= ft_q - size_q + (ave_q[31:0] - rsq_q[31:0] - H32);
        end
        ffba_pkg::S_AL_W2: begin
          cnt_q    <= CW'(cnt_q + 1'b1);
          status_q <= ffba_pkg::ST_OK;
        end
        ffba_pkg::S_FR_CMP: begin
          if (free_hit) begin
            if (!occ_q) status_q <= ffba_pkg::ST_NOT_OCC;
            else        ft_q     <= ft_q + size_q;
          end
        end
        ffba_pkg::S_FR_PEV, ffba_pkg::S_FR_NEV: begin
          if (!mem_rdata.occ) ft_q <= ft_q + H32;
        end
        ffba_pkg::S_RM_RD: begin
          if (ptr_q == cnt_q) begin
            cnt_q    <= CW'(cnt_q - kmrg);
            status_q <= ffba_pkg::ST_OK;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (st_q)
      ffba_pkg::S_IDLE: begin
        kind_q  <= req_i.kind;
        reqsz_q <= req_i.request_size;
        faddr_q <= req_i.free_address;
        amask_q <= 13'(apow - 13'd1);
        scn_q   <= '0;
        addr_q  <= '0;
      end
      ffba_pkg::S_SCAN_EV: begin
        hdr_q  <= mem_rdata.hdr;
        size_q <= mem_rdata.size;
        occ_q  <= mem_rdata.occ;
        avs_q  <= {1'b0, mem_rdata.hdr} + 33'(HEADER_BYTES);
        ave_q  <= {2'b0, mem_rdata.hdr} + 34'(HEADER_BYTES) + {2'b0, mem_rdata.size};
        if (kind_q != ffba_pkg::KIND_FREE && mem_rdata.occ) scn_q <= scn_p1;
      end
      ffba_pkg::S_AL_RS: rs_q  <= ({1'b0, avs_q} + {21'b0, amask_q}) & ~{21'b0, amask_q};
      ffba_pkg::S_AL_RQ: rsq_q <= {1'b0, rs_q} + {3'b0, reqsz_q};
      ffba_pkg::S_AL_CMP: begin
        if (!alloc_fit) scn_q <= scn_p1;
        ptr_q <= CW'(cnt_q - 1'b1);
      end
      ffba_pkg::S_INS_WR: ptr_q <= CW'(ptr_q - 1'b1);
      ffba_pkg::S_AL_W2:  addr_q <= rs_q[31:0];
      ffba_pkg::S_FR_CMP: begin
        if (!free_hit) scn_q <= scn_p1;
        acc_q   <= size_q;
        mhdr_q  <= hdr_q;
        pfree_q <= 1'b0;
        nfree_q <= 1'b0;
      end
      ffba_pkg::S_FR_PEV: begin
        if (!mem_rdata.occ) begin
          pfree_q <= 1'b1;
          acc_q   <= acc_q + mem_rdata.size + H32;
          mhdr_q  <= mem_rdata.hdr;
        end
      end
      ffba_pkg::S_FR_NEV: begin
        if (!mem_rdata.occ) begin
          nfree_q <= 1'b1;
          acc_q   <= acc_q + mem_rdata.size + H32;
        end
      end
      ffba_pkg::S_FR_WM: ptr_q <= CW'(scn_p1 + {{(CW-1){1'b0}}, nfree_q});
      ffba_pkg::S_RM_WR: ptr_q <= ptr_p1;
      default: ;
    endcase
  end

  // Result ports
  assign busy                   = (st_q != ffba_pkg::S_IDLE);
  assign done_o                 = (st_q == ffba_pkg::S_DONE);
  assign res_o.status           = status_q;
  assign res_o.payload_address  = addr_q;
  assign res_o.free_bytes       = ft_q;

endmodule

`default_nettype wire

>>> sv/ffba_checker.sv
// Port-level checks of the allocator, bound to the top level.
// Depends on ffba_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ffba_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           done_o,
  input wire ffba_pkg::out_item_t res_o
);

  // A result only shows while a transaction is in flight
  `ASSERT_CLK(a_done_busy, clk_i, rst_ni, done_o |-> busy)
  // An accepted transaction makes the block busy
  `ASSERT_CLK(a_accept_busy, clk_i, rst_ni, (start && !busy) |=> busy)
  // Block returns to idle right after a result
  `ASSERT_CLK(a_done_idle, clk_i, rst_ni, done_o |=> !busy)
  // A nonzero address only comes with a good status
  `ASSERT_NEVER(a_addr_status, clk_i, rst_ni,
    done_o && res_o.payload_address != '0 && res_o.status != ffba_pkg::ST_OK)

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .done_o(done_o),
  .res_o (res_o)
);

`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench of first_fit_block_allocator: random and directed transactions,
// with the results checked against an in-bench model of the block table.
// Depends on ffba_pkg and the allocator RTL only.
`timescale 1ns / 100ps

module tb;

  localparam int HDR_BYTES  = 16;
  localparam int TABLE_SIZE = 64;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 3000000;

  typedef enum int {OP_CFG, OP_ITEM, OP_FREE_LIVE, OP_PAUSE} op_kind_e;
  typedef struct {
    op_kind_e           op;
    ffba_pkg::cfg_idx_e idx;
    logic [31:0]        data;
    ffba_pkg::in_item_t item;
  } op_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  ffba_pkg::in_item_t  req_i = '0;
  logic      done_o;
  ffba_pkg::out_item_t res_o;
  logic      cfg_we_i = 1'b0;
  logic      cfg_idx_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;

  first_fit_block_allocator dut (
    .clk_i, .rst_ni, .start, .busy, .req_i, .done_o, .res_o,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Block table model
  logic [31:0] blk_hdr [TABLE_SIZE];
  logic [31:0] blk_size [TABLE_SIZE];
  bit          blk_occ [TABLE_SIZE];
  int          blk_cnt = 0;
  logic [31:0] reg_base = '0;
  logic [31:0] reg_size = '0;

  op_t                 pending_ops [$];
  ffba_pkg::out_item_t expected_results [$];
  int        mismatches = 0;
  bit        stim_done = 1'b0;

  function automatic void drop_block(int i);
    for (int j = i; j < blk_cnt - 1; j++) begin
      blk_hdr[j]  = blk_hdr[j+1];
      blk_size[j] = blk_size[j+1];
      blk_occ[j]  = blk_occ[j+1];
    end
    blk_cnt--;
  endfunction

  // Apply one accepted transaction to the model and queue its result
  function automatic void predict_result(ffba_pkg::in_item_t it);
    ffba_pkg::out_item_t r;
    logic [63:0] span, al, s, e, rs;
    logic [31:0] sum;
    int          i;
    r = '0;
    case (it.kind)
      ffba_pkg::KIND_INIT: begin
        span = {32'd0, reg_size};
        if (64'(reg_base) + span > 64'h1_0000_0000)
          span = 64'h1_0000_0000 - 64'(reg_base);
        if (reg_size < HDR_BYTES || span < HDR_BYTES) begin
          r.status = ffba_pkg::ST_TOO_SMALL;
        end else begin
          blk_cnt = 1;
          blk_hdr[0] = reg_base;
          blk_size[0] = 32'(span - HDR_BYTES);
          blk_occ[0] = 1'b0;
          r.status = ffba_pkg::ST_OK;
        end
      end
      ffba_pkg::KIND_ALLOC: begin
        al = 1;
        while ((al << 1) <= 64'(it.alignment)) al = al << 1;
        r.status = ffba_pkg::ST_NULL;
        if (it.request_size != 0) begin
          for (i = 0; i < blk_cnt; i++) begin
            if (blk_occ[i]) continue;
            s  = 64'(blk_hdr[i]) + HDR_BYTES;
            e  = s + blk_size[i];
            rs = (s + al - 1) & ~(al - 1);
            if (rs + it.request_size + HDR_BYTES > e) continue;
            if (blk_cnt >= TABLE_SIZE) begin
              r.status = ffba_pkg::ST_FULL;
              break;
            end
            for (int j = blk_cnt - 1; j > i; j--) begin
              blk_hdr[j+1]  = blk_hdr[j];
              blk_size[j+1] = blk_size[j];
              blk_occ[j+1]  = blk_occ[j];
            end
            blk_hdr[i+1]  = 32'(rs + it.request_size);
            blk_size[i+1] = 32'(e - (rs + it.request_size + HDR_BYTES));
            blk_occ[i+1]  = 1'b0;
            blk_cnt++;
            blk_occ[i]  = 1'b1;
            blk_size[i] = 32'(rs + it.request_size - s);
            r.status = ffba_pkg::ST_OK;
            r.payload_address = 32'(rs);
            break;
          end
        end
      end
      ffba_pkg::KIND_FREE: begin
        for (i = 0; i < blk_cnt; i++)
          if (64'(it.free_address) >= 64'(blk_hdr[i]) &&
              64'(it.free_address) <= 64'(blk_hdr[i]) + HDR_BYTES + blk_size[i])
            break;
        if (i >= blk_cnt) begin
          r.status = ffba_pkg::ST_UNKNOWN;
        end else if (!blk_occ[i]) begin
          r.status = ffba_pkg::ST_NOT_OCC;
        end else begin
          blk_occ[i] = 1'b0;
          while (i + 1 < blk_cnt && !blk_occ[i+1]) begin
            blk_size[i] += HDR_BYTES + blk_size[i+1];
            drop_block(i + 1);
          end
          while (i > 0 && !blk_occ[i-1]) begin
            blk_size[i-1] += HDR_BYTES + blk_size[i];
            drop_block(i);
            i--;
          end
          r.status = ffba_pkg::ST_OK;
        end
      end
      default: r.status = ffba_pkg::ST_NULL;
    endcase
    sum = '0;
    for (i = 0; i < blk_cnt; i++)
      if (!blk_occ[i]) sum += blk_size[i];
    r.free_bytes = sum;
    expected_results.push_back(r);
  endfunction

  // Release of a live allocation, or a stray address when none is live
  function automatic ffba_pkg::in_item_t pick_live_free();
    ffba_pkg::in_item_t it;
    int       live [$];
    int       k;
    it = '0;
    it.kind = ffba_pkg::KIND_FREE;
    it.free_address = $urandom;
    for (int i = 0; i < blk_cnt; i++)
      if (blk_occ[i]) live.push_back(i);
    if (live.size() != 0) begin
      k = live[$urandom_range(0, live.size() - 1)];
      case ($urandom_range(0, 3))
        0: it.free_address = blk_hdr[k];
        1: it.free_address = blk_hdr[k] + HDR_BYTES + $urandom_range(0, blk_size[k]);
        default: it.free_address = blk_hdr[k] + HDR_BYTES;
      endcase
    end
    return it;
  endfunction

  // Driver: one transaction at a time, bursts with random gaps
  int burst_left = 5;
  int gap_left = 0;
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    logic     nxt_start;
    logic     nxt_we;
    op_t      op;
    ffba_pkg::in_item_t it;
    nxt_start = start;
    nxt_we = 1'b0;
    if (rst_ni) begin
      if (start && !busy) begin
        predict_result(req_i);
        nxt_start = 1'b0;
      end
      if (expected_results.size() == 0 && !busy && !start) idle_cycles++;
      else idle_cycles = 0;
      if (!nxt_start && pending_ops.size() != 0) begin
        op = pending_ops[0];
        case (op.op)
          OP_CFG: begin
            if (idle_cycles >= 4 && !cfg_we_i) begin
              nxt_we = 1'b1;
              cfg_idx_i <= op.idx;
              cfg_wdata_i <= op.data;
              if (op.idx == ffba_pkg::CFG_REGION_BASE) reg_base = op.data;
              else reg_size = op.data;
              void'(pending_ops.pop_front());
            end
          end
          OP_PAUSE: begin
            if (expected_results.size() == 0 && !start) void'(pending_ops.pop_front());
          end
          default: begin
            if (gap_left > 0) begin
              gap_left--;
            end else begin
              it = (op.op == OP_FREE_LIVE) ? pick_live_free() : op.item;
              req_i <= it;
              nxt_start = 1'b1;
              void'(pending_ops.pop_front());
              if (--burst_left <= 0) begin
                burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 12);
                gap_left = $urandom_range(0, 4) == 0 ? $urandom_range(5, 30)
                                                     : $urandom_range(0, 3);
              end
            end
          end
        endcase
      end
    end
    start <= nxt_start;
    cfg_we_i <= nxt_we;
  end

  // Monitor: every strobed result against the oldest expectation
  always @(posedge clk_i) begin
    ffba_pkg::out_item_t want;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", res_o);
      end else begin
        want = expected_results.pop_front();
        if (res_o.status != want.status || res_o.payload_address != want.payload_address ||
            res_o.free_bytes != want.free_bytes) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected st=%0d addr=%h free=%h, got st=%0d addr=%h free=%h",
                     want.status, want.payload_address, want.free_bytes,
                     res_o.status, res_o.payload_address, res_o.free_bytes);
        end
      end
    end
  end

  // Watchdog
  int cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  function automatic void add_cfg(ffba_pkg::cfg_idx_e idx, logic [31:0] v);
    op_t o;
    o.op = OP_CFG; o.idx = idx; o.data = v; o.item = '0;
    pending_ops.push_back(o);
  endfunction

  function automatic void add_item(logic [1:0] kind, logic [31:0] sz, logic [12:0] al,
                                   logic [31:0] fa);
    op_t o;
    o.op = OP_ITEM; o.idx = ffba_pkg::CFG_REGION_BASE; o.data = '0;
    o.item.kind = kind; o.item.request_size = sz;
    o.item.alignment = al; o.item.free_address = fa;
    pending_ops.push_back(o);
  endfunction

  function automatic void add_marker(op_kind_e k);
    op_t o;
    o.op = k; o.idx = ffba_pkg::CFG_REGION_BASE; o.data = '0; o.item = '0;
    pending_ops.push_back(o);
  endfunction

  // Stimulus
  initial begin
    logic [31:0] bases [6];
    logic [31:0] sizes [6];
    logic [31:0] sz;
    logic [12:0] al;
    int          pick;

    // before any init: empty table, unknown kind, region too small
    add_item(ffba_pkg::KIND_ALLOC, 32'd64, 13'd8, '0);
    add_item(ffba_pkg::KIND_FREE, '0, 13'd1, 32'hFFFF_FFFF);
    add_item(KIND_UNUSED, 32'd16, 13'd1, '0);
    add_item(ffba_pkg::KIND_INIT, '0, 13'd1, '0);
    add_cfg(ffba_pkg::CFG_REGION_BASE, 32'hFFFF_FFF8);
    add_cfg(ffba_pkg::CFG_REGION_SIZE, 32'hFFFF_FFFF);
    add_item(ffba_pkg::KIND_INIT, '0, 13'd1, '0);
    // region cut at the top of memory
    add_cfg(ffba_pkg::CFG_REGION_BASE, 32'hFFFF_F000);
    add_item(ffba_pkg::KIND_INIT, '0, 13'd1, '0);
    add_item(ffba_pkg::KIND_ALLOC, 32'd0, 13'd4, '0);
    add_item(ffba_pkg::KIND_ALLOC, 32'd100, 13'd0, '0);
    add_item(ffba_pkg::KIND_ALLOC, 32'd33, 13'h1FFF, '0);
    add_item(ffba_pkg::KIND_ALLOC, 32'd7, 13'd4096, '0);
    add_item(ffba_pkg::KIND_ALLOC, 32'd24, 13'd6, '0);
    add_item(ffba_pkg::KIND_ALLOC, 32'hFFFF_FFFF, 13'd1, '0);
    add_item(ffba_pkg::KIND_FREE, '0, 13'd1, 32'hFFFF_FFF0);
    add_item(ffba_pkg::KIND_FREE, '0, 13'd1, 32'd0);
    add_marker(OP_FREE_LIVE);
    add_marker(OP_FREE_LIVE);
    add_item(ffba_pkg::KIND_INIT, '0, 13'd1, '0);
    add_marker(OP_PAUSE);

    // region settings, extremes included
    bases[0] = 32'h0000_1000; sizes[0] = 32'd4096;
    bases[1] = 32'h0000_0000; sizes[1] = 32'hFFFF_FFFF;
    bases[2] = 32'hFFFF_FFF0; sizes[2] = 32'd16;
    bases[3] = 32'h8000_0000; sizes[3] = 32'h0001_0000;
    bases[4] = $urandom;      sizes[4] = $urandom;
    bases[5] = 32'h0000_4000; sizes[5] = 32'd2048;

    for (int ph = 0; ph < 6; ph++) begin
      add_cfg(ffba_pkg::CFG_REGION_BASE, bases[ph]);
      add_cfg(ffba_pkg::CFG_REGION_SIZE, sizes[ph]);
      add_item(ffba_pkg::KIND_INIT, '0, 13'd1, '0);
      for (int n = 0; n < 190; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 52) begin
          sz = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 96);
          al = ($urandom_range(0, 4) == 0) ? 13'($urandom) : 13'(1 << $urandom_range(0, 6));
          add_item(ffba_pkg::KIND_ALLOC, sz, al, $urandom);
        end else if (pick < 92) begin
          add_marker(OP_FREE_LIVE);
        end else if (pick < 97) begin
          add_item(ffba_pkg::KIND_FREE, $urandom, 13'($urandom), $urandom);
        end else if (pick < 99) begin
          add_item(ffba_pkg::KIND_INIT, $urandom, 13'($urandom), $urandom);
        end else begin
          add_item(KIND_UNUSED, $urandom, 13'($urandom), $urandom);
        end
        if (n == 95) add_marker(OP_PAUSE);
      end
      add_marker(OP_PAUSE);
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_ops.size() == 0 && !start && expected_results.size() == 0);
    repeat (400) begin
      @(posedge clk_i);
      if (done_o) ;
    end
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
